[rtl/cri_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package cri_pkg;

  localparam int CRI_EXP_TABLE_DEPTH = 256;

  localparam logic [23:0] MAX24 = 24'hFF_FFFF;

  // Reset values of the configuration registers.
  localparam logic [15:0] EXTINCTION_COEF_RST    = 16'd2048;
  localparam logic [15:0] LEAF_STORAGE_RST       = 16'd819;
  localparam logic [23:0] STEM_STORAGE_RST       = 24'd1638;
  localparam logic [16:0] STEM_FLOW_FRACTION_RST = 17'd3277;
  localparam logic [15:0] LAI_FLOOR_RST          = 16'd410;

  localparam logic [16:0] FRACTION_ONE = 17'h1_0000;
  localparam int          DIV_STEPS    = 24;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_EXTINCTION_COEF    = 3'd0,
    CFG_LEAF_STORAGE       = 3'd1,
    CFG_STEM_STORAGE       = 3'd2,
    CFG_STEM_FLOW_FRACTION = 3'd3,
    CFG_LAI_FLOOR          = 3'd4
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_X,
    ST_POS,
    ST_ROM0,
    ST_ROM1,
    ST_INTERP,
    ST_GAP,
    ST_FREE,
    ST_CAPM,
    ST_CAP,
    ST_DRAIN,
    ST_STEM,
    ST_STEMR,
    ST_DIVINIT,
    ST_DIV,
    ST_FIN
  } cri_state_t;

  typedef struct packed {
    logic [23:0] rain_depth;
    logic [23:0] potential_evaporation;
    logic [15:0] leaf_area;
  } cri_in_t;

  typedef struct packed {
    logic [23:0] throughfall;
    logic [23:0] free_rain;
    logic [23:0] canopy_drainage;
    logic [23:0] stem_flow;
    logic [23:0] water_on_canopy;
  } cri_out_t;

endpackage

`default_nettype wire

[rtl/cri_in_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cri_in_if;
  import cri_pkg::*;

  logic    valid;
  logic    ready;
  cri_in_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/cri_out_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface cri_out_if;
  import cri_pkg::*;

  logic     valid;
  logic     ready;
  cri_out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

[rtl/canopy_rain_interception_step.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake        Payload
// in_ch     sink       valid / ready    rain_depth, potential_evaporation, leaf_area
// out_ch    source     valid / ready    throughfall, free_rain, canopy_drainage,
//                                       stem_flow, water_on_canopy
// cfg_*     write      cfg_we           cfg_index selects the register, cfg_wdata
//
// One time step runs through the sequencer states from one input transfer to the
// next; when the evaporation is proportional it also passes through the
// one-bit-per-cycle restoring divider. All products go through a single
// 32 x 32 multiplier, one product per cycle, and the exponential table is a ROM
// with a registered read port that is read twice per item.
// Reset is synchronous and active low; it clears the sequencer, the output valid
// flag and the stored canopy water, and loads the configuration reset values.
// A finished result waits in the output register; the block takes the next item
// meanwhile and only holds in its last step if the old result is still there.

module canopy_rain_interception_step
  import cri_pkg::*;
#(
  parameter int EXP_TABLE_DEPTH = CRI_EXP_TABLE_DEPTH
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   cfg_we,
  input  wire [CFG_INDEX_W-1:0] cfg_index,
  input  wire [CFG_DATA_W-1:0]  cfg_wdata,
  cri_in_if.sink                in_ch,
  cri_out_if.source             out_ch
);

  localparam int IDXW = $clog2(EXP_TABLE_DEPTH + 1);

  typedef logic [32:0] exp_tab_t [0:EXP_TABLE_DEPTH];

  // Builds exp(-16*i/EXP_TABLE_DEPTH) in Q1.32 by repeated multiplication with
  // the per-entry ratio, which itself comes from a truncated Taylor series.
  // Evaluated only at elaboration.
  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] d;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] prod;
    d    = (64'd1 << 36) / 64'(EXP_TABLE_DEPTH);
    term = 64'd1 << 32;
    sum  = term;
    for (int n = 1; n <= 20; n++) begin
      term = ((term * d) >> 32) / 64'(n);
      if ((n % 2) == 1) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    tab[0] = 33'h1_0000_0000;
    for (int i = 1; i <= EXP_TABLE_DEPTH; i++) begin
      prod   = 64'(tab[i-1]) * sum + (64'd1 << 31);
      tab[i] = 33'(prod >> 32);
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  // Configuration registers.
  logic [15:0] extinction_coef_r;
  logic [15:0] leaf_storage_r;
  logic [23:0] stem_storage_r;
  logic [16:0] stem_flow_fraction_r;
  logic [15:0] lai_floor_r;

  // Sequencer and state.
  cri_state_t  state_r;
  cri_state_t  state_nxt;
  logic [23:0] cw_r;
  logic        out_valid_r;
  cri_out_t    out_data_r;

  // Datapath registers.
  logic [23:0]     rain_r;
  logic [23:0]     pe_r;
  logic [15:0]     lai_r;
  logic [63:0]     mul_r;
  logic [32:0]     rom_q_r;
  logic [32:0]     t0_r;
  logic [IDXW-1:0] idx_r;
  logic [23:0]     f_r;
  logic [16:0]     gap_r;
  logic [23:0]     freer_r;
  logic [23:0]     cap_r;
  logic [24:0]     gross_r;
  logic [24:0]     drain_r;
  logic            small_r;
  logic            full_r;
  logic [24:0]     stem_r;
  logic [23:0]     rem_r;
  logic [23:0]     q_r;
  logic [4:0]      cnt_r;

  // Control outputs of the sequencer.
  logic [31:0]     mul_a;
  logic [31:0]     mul_b;
  logic [IDXW-1:0] rom_addr;
  logic            in_ready;
  logic            fin_go;

  // Combinational datapath terms.
  logic [15:0]     lcov;
  logic [28:0]     x_clamped;
  logic [IDXW-1:0] pos_idx;
  logic [IDXW-1:0] idx_next;
  logic [32:0]     e_val;
  logic [33:0]     gap_sum;
  logic [40:0]     freer_sum;
  logic [32:0]     cap_sum;
  logic [24:0]     cap_full;
  logic [28:0]     gross_x10;
  logic [16:0]     frac;
  logic [41:0]     stem_sum;
  logic [24:0]     div_trial;
  logic [24:0]     div_diff;
  logic            div_bit;
  logic [25:0]     thr_full;
  logic signed [26:0] left_full;
  logic [23:0]     left_sat;

  wire in_xfer  = in_ch.valid && in_ready;
  wire out_xfer = out_valid_r && out_ch.ready;

  assign in_ch.ready  = in_ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = out_data_r;

  // The shared multiplier; its product is registered every cycle.
  wire [63:0] mul_p = 64'(mul_a) * 64'(mul_b);

  assign lcov      = (lai_r < lai_floor_r) ? lai_floor_r : lai_r;
  assign x_clamped = (mul_r[31:0] > 32'h1000_0000) ? 29'h1000_0000 : mul_r[28:0];
  // Table position is x * depth / 16, x in Q.24: integer part from bit 28 up.
  assign pos_idx   = mul_r[28 +: IDXW];
  assign idx_next  = (idx_r == IDXW'(EXP_TABLE_DEPTH)) ? idx_r : idx_r + IDXW'(1);
  assign e_val     = t0_r - {1'b0, mul_r[55:24]};
  assign gap_sum   = {1'b0, e_val} + 34'd32768;
  assign freer_sum = mul_r[40:0] + 41'd32768;
  assign cap_sum   = {1'b0, mul_r[31:0]} + 33'd2048;
  assign cap_full  = {5'd0, cap_sum[31:12]} + {1'b0, stem_storage_r};
  assign gross_x10 = {1'b0, gross_r, 3'd0} + {3'd0, gross_r, 1'b0};
  assign frac      = (stem_flow_fraction_r > FRACTION_ONE) ? FRACTION_ONE
                                                           : stem_flow_fraction_r;
  assign stem_sum  = mul_r[41:0] + 42'd32768;

  // One restoring divider step: bring in the next dividend bit, try the subtract.
  assign div_trial = {rem_r, q_r[23]};
  assign div_diff  = div_trial - {1'b0, cap_r};
  assign div_bit   = (div_trial >= {1'b0, cap_r});

  // q_r holds the evaporation once the last computing step is done.
  assign thr_full  = {2'd0, freer_r} + {1'b0, drain_r} - {1'b0, stem_r};
  assign left_full = $signed({2'd0, gross_r}) - $signed({3'd0, q_r})
                     - $signed({2'd0, drain_r});
  always_comb begin
    if (left_full < 0) begin
      left_sat = 24'd0;
    end else if (left_full > $signed({3'd0, MAX24})) begin
      left_sat = MAX24;
    end else begin
      left_sat = left_full[23:0];
    end
  end

  assign fin_go = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (in_xfer) state_nxt = ST_MUL_X;
      ST_MUL_X:   state_nxt = ST_POS;
      ST_POS:     state_nxt = ST_ROM0;
      ST_ROM0:    state_nxt = ST_ROM1;
      ST_ROM1:    state_nxt = ST_INTERP;
      ST_INTERP:  state_nxt = ST_GAP;
      ST_GAP:     state_nxt = ST_FREE;
      ST_FREE:    state_nxt = ST_CAPM;
      ST_CAPM:    state_nxt = ST_CAP;
      ST_CAP:     state_nxt = ST_DRAIN;
      ST_DRAIN:   state_nxt = ST_STEM;
      ST_STEM:    state_nxt = ST_STEMR;
      ST_STEMR:   state_nxt = ST_DIVINIT;
      ST_DIVINIT: state_nxt = (small_r || full_r) ? ST_FIN : ST_DIV;
      ST_DIV:     if (cnt_r == 5'(DIV_STEPS - 1)) state_nxt = ST_FIN;
      ST_FIN:     if (fin_go) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: multiplier operands, table address, input ready.
  always_comb begin
    mul_a    = 32'd0;
    mul_b    = 32'd0;
    rom_addr = pos_idx;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE:  in_ready = 1'b1;
      ST_MUL_X: begin
        mul_a = {16'd0, extinction_coef_r};
        mul_b = {16'd0, lcov};
      end
      ST_POS: begin
        mul_a = {3'd0, x_clamped};
        mul_b = 32'(EXP_TABLE_DEPTH);
      end
      ST_ROM1:  rom_addr = idx_next;
      ST_INTERP: begin
        mul_a = 32'(t0_r - rom_q_r);
        mul_b = {8'd0, f_r};
      end
      ST_FREE: begin
        mul_a = {8'd0, rain_r};
        mul_b = {15'd0, gap_r};
      end
      ST_CAPM: begin
        mul_a = {16'd0, leaf_storage_r};
        mul_b = {16'd0, lai_r};
      end
      ST_STEM: begin
        mul_a = {7'd0, drain_r};
        mul_b = {15'd0, frac};
      end
      ST_STEMR: begin
        mul_a = {8'd0, pe_r};
        mul_b = {8'd0, gross_r[23:0]};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes, the stored canopy water and the output valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      extinction_coef_r    <= EXTINCTION_COEF_RST;
      leaf_storage_r       <= LEAF_STORAGE_RST;
      stem_storage_r       <= STEM_STORAGE_RST;
      stem_flow_fraction_r <= STEM_FLOW_FRACTION_RST;
      lai_floor_r          <= LAI_FLOOR_RST;
      cw_r                 <= 24'd0;
      out_valid_r          <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_EXTINCTION_COEF:    extinction_coef_r    <= cfg_wdata[15:0];
          CFG_LEAF_STORAGE:       leaf_storage_r       <= cfg_wdata[15:0];
          CFG_STEM_STORAGE:       stem_storage_r       <= cfg_wdata[23:0];
          CFG_STEM_FLOW_FRACTION: stem_flow_fraction_r <= cfg_wdata[16:0];
          CFG_LAI_FLOOR:          lai_floor_r          <= cfg_wdata[15:0];
          default: begin
          end
        endcase
      end
      if (fin_go) begin
        cw_r <= left_sat;
      end
      priority if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_xfer) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Table ROM with a registered read.
  always_ff @(posedge clk) begin
    rom_q_r <= EXP_TAB[rom_addr];
  end

  // Datapath registers, loaded step by step.
  always_ff @(posedge clk) begin
    mul_r <= mul_p;
    if (in_xfer) begin
      rain_r <= in_ch.data.rain_depth;
      pe_r   <= in_ch.data.potential_evaporation;
      lai_r  <= in_ch.data.leaf_area;
    end
    unique case (state_r)
      ST_ROM0: begin
        idx_r <= pos_idx;
        f_r   <= mul_r[27:4];
      end
      ST_ROM1:  t0_r <= rom_q_r;
      ST_GAP:   gap_r <= gap_sum[32:16];
      ST_CAPM:  freer_r <= freer_sum[39:16];
      ST_CAP: begin
        cap_r   <= (cap_full > {1'b0, MAX24}) ? MAX24 : cap_full[23:0];
        gross_r <= {1'b0, cw_r} + {1'b0, rain_r} - {1'b0, freer_r};
      end
      ST_DRAIN: begin
        drain_r <= (gross_r > {1'b0, cap_r}) ? gross_r - {1'b0, cap_r} : 25'd0;
        small_r <= (gross_x10 < {5'd0, cap_r});
        full_r  <= (gross_r >= {1'b0, cap_r});
      end
      ST_STEMR: stem_r <= stem_sum[40:16];
      ST_DIVINIT: begin
        // Below a tenth of capacity everything evaporates; at or above capacity
        // the full demand does; in between the demand is scaled by gross/capacity.
        priority if (small_r) begin
          q_r <= gross_r[23:0];
        end else if (full_r) begin
          q_r <= pe_r;
        end else begin
          rem_r <= mul_r[47:24];
          q_r   <= mul_r[23:0];
        end
        cnt_r <= 5'd0;
      end
      ST_DIV: begin
        rem_r <= div_bit ? div_diff[23:0] : div_trial[23:0];
        q_r   <= {q_r[22:0], div_bit};
        cnt_r <= cnt_r + 5'd1;
      end
      default: begin
      end
    endcase
    if (fin_go) begin
      out_data_r.throughfall     <= (thr_full > {2'd0, MAX24}) ? MAX24 : thr_full[23:0];
      out_data_r.free_rain       <= freer_r;
      out_data_r.canopy_drainage <= (drain_r > {1'b0, MAX24}) ? MAX24 : drain_r[23:0];
      out_data_r.stem_flow       <= (stem_r > {1'b0, MAX24}) ? MAX24 : stem_r[23:0];
      out_data_r.water_on_canopy <= left_sat;
    end
  end

endmodule

`default_nettype wire
